// File: rtl/core/cgm_pkg.sv
// Shared types, constants and arithmetic helpers of the context-gated mixer.
package cgm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DefMaxContexts = 1024;
  localparam int unsigned DefMaxInputs   = 64;

  // Request function codes.
  localparam logic [1:0] FuncLoad     = 2'd0;
  localparam logic [1:0] FuncMix      = 2'd1;
  localparam logic [1:0] FuncPerceive = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegMainCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExtraCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLearnRate   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStartWeight = 2'd3;

  // Step-count decay schedule, Q1.16.
  localparam logic [24:0] StepThr1 = 25'd1000000;
  localparam logic [24:0] StepThr2 = 25'd5000000;
  localparam logic [24:0] StepThr3 = 25'd25000000;
  localparam logic [24:0] StepMax  = 25'h1FF_FFFF;
  localparam logic [16:0] Decay0   = 17'd65536;
  localparam logic [16:0] Decay1   = 17'd45875;
  localparam logic [16:0] Decay2   = 17'd19661;
  localparam logic [16:0] Decay3   = 17'd13107;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic store_wr;
    logic k_clr;
    logic k_inc;
    logic ins;
    logic hit;
    logic fb;
    logic i_clr;
    logic i_inc;
    logic acc_clr;
    logic mac;
    logic wt_init;
    logic fill;
    logic out_load;
    logic logi;
    logic prod;
    logic upd;
    logic dmul;
    logic wwr;
  } cgm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_end;
    logic full;
    logic tag_eq;
    logic i_n;
    logic i_all;
    logic ins;
    logic sw_wr;
    logic out_free;
    logic tiny;
  } cgm_sts_t;

  // Logistic table, logistic(k/2) in Q0.16 for k = 0..16.
  function automatic logic [16:0] logi_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd32768;
      5'd1:  v = 17'd40793;
      5'd2:  v = 17'd47911;
      5'd3:  v = 17'd53581;
      5'd4:  v = 17'd57724;
      5'd5:  v = 17'd60565;
      5'd6:  v = 17'd62428;
      5'd7:  v = 17'd63615;
      5'd8:  v = 17'd64357;
      5'd9:  v = 17'd64816;
      5'd10: v = 17'd65097;
      5'd11: v = 17'd65269;
      5'd12: v = 17'd65374;
      5'd13: v = 17'd65438;
      5'd14: v = 17'd65476;
      5'd15: v = 17'd65500;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

  // Interpolated logistic of a Q16.16 value, mirrored for negative inputs.
  function automatic logic [16:0] logistic_q16(input logic signed [31:0] p);
    logic [31:0] a;
    logic [3:0]  idx;
    logic [14:0] frac;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [16:0] s;
    logic [13:0] d;
    logic [29:0] ip;
    a    = p[31] ? (32'd0 - 32'(p)) : 32'(p);
    idx  = a[18:15];
    frac = a[14:0];
    t0   = logi_tab({1'b0, idx});
    t1   = logi_tab({1'b0, idx} + 5'd1);
    d    = 14'(t1 - t0);
    ip   = 30'(d) * 30'(frac) + 30'd16384;
    if (a >= 32'h0008_0000) begin
      s = logi_tab(5'd16);
    end else begin
      s = t0 + 17'(ip >> 15);
    end
    return p[31] ? (17'd65536 - s) : s;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cgm_if.sv
// Request and result channel interfaces of the mixer.
interface cgm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [5:0]        elem_index;
  logic signed [15:0] elem_value;
  logic [63:0]       ctx_key;
  logic              coded_bit;

  modport source (output valid, func, elem_index, elem_value, ctx_key, coded_bit,
                  input ready);
  modport sink (input valid, func, elem_index, elem_value, ctx_key, coded_bit,
                output ready);
endinterface

interface cgm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prediction;
  logic               used_fallback;

  modport source (output valid, prediction, used_fallback, input ready);
  modport sink (input valid, prediction, used_fallback, output ready);
endinterface

// File: rtl/core/cgm_ram.sv
// Generic single-port RAM with registered read data.
module cgm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-before-write: the registered read data holds the old word when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/core/cgm_ctrl.sv
// Controller state machine of the mixer: sequences load, mix and perceive requests.
module cgm_ctrl import cgm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  output logic       in_ready_o,
  input  cgm_sts_t   sts_i,
  output cgm_cmd_t   cmd_o
);
  typedef enum logic [3:0] {
    StFill, StIdle, StLoad, StSrch, StScmp, StMrd, StMmac, StMout,
    StPlogi, StPprod, StPu, StUrd, StUmul, StUwr
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StFill: begin
        if (sts_i.i_all && !sts_i.sw_wr) begin
          state_d = StIdle;
        end else begin
          cmd_o.fill    = 1'b1;
          cmd_o.wt_init = 1'b1;
          cmd_o.i_inc   = 1'b1;
        end
      end
      StIdle: begin
        if (sts_i.sw_wr) begin
          state_d = StFill;
        end else if (accept) begin
          cmd_o.latch = 1'b1;
          case (in_func_i)
            FuncLoad: state_d = StLoad;
            FuncMix: begin
              cmd_o.k_clr = 1'b1;
              state_d     = StSrch;
            end
            FuncPerceive: state_d = StPlogi;
            default: state_d = StIdle;
          endcase
        end
      end
      StLoad: begin
        cmd_o.store_wr = 1'b1;
        state_d        = StIdle;
      end
      StSrch: begin
        if (sts_i.k_end) begin
          cmd_o.i_clr   = 1'b1;
          cmd_o.acc_clr = 1'b1;
          if (sts_i.full) begin
            cmd_o.fb = 1'b1;
          end else begin
            cmd_o.ins = 1'b1;
          end
          state_d = StMrd;
        end else begin
          state_d = StScmp;
        end
      end
      StScmp: begin
        if (sts_i.tag_eq) begin
          cmd_o.hit     = 1'b1;
          cmd_o.i_clr   = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = StMrd;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = StSrch;
        end
      end
      StMrd: begin
        if (sts_i.ins ? sts_i.i_all : sts_i.i_n) begin
          state_d = StMout;
        end else begin
          state_d = StMmac;
        end
      end
      StMmac: begin
        cmd_o.mac     = 1'b1;
        cmd_o.wt_init = sts_i.ins;
        cmd_o.i_inc   = 1'b1;
        state_d       = StMrd;
      end
      StMout: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StPlogi: begin
        cmd_o.logi = 1'b1;
        state_d    = StPprod;
      end
      StPprod: begin
        cmd_o.prod = 1'b1;
        state_d    = StPu;
      end
      StPu: begin
        if (sts_i.tiny) begin
          state_d = StIdle;
        end else begin
          cmd_o.upd   = 1'b1;
          cmd_o.i_clr = 1'b1;
          state_d     = StUrd;
        end
      end
      StUrd: begin
        state_d = sts_i.i_n ? StIdle : StUmul;
      end
      StUmul: begin
        cmd_o.dmul = 1'b1;
        state_d    = StUwr;
      end
      StUwr: begin
        cmd_o.wwr   = 1'b1;
        cmd_o.i_inc = 1'b1;
        state_d     = StUrd;
      end
      default: state_d = StIdle;
    endcase
  end

  // State register; the fallback weights are filled after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFill;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: rtl/core/cgm_dp.sv
// Datapath of the mixer: registers, tag search, multiply-accumulate and weight update.
module cgm_dp import cgm_pkg::*; #(
  parameter int unsigned MaxContexts = DefMaxContexts,
  parameter int unsigned MaxInputs   = DefMaxInputs
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          elem_index_i,
  input  logic signed [15:0]  elem_value_i,
  input  logic [63:0]         ctx_key_i,
  input  logic                coded_bit_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  prediction_o,
  output logic                used_fallback_o,
  input  cgm_cmd_t            cmd_i,
  output cgm_sts_t            sts_o
);
  localparam int unsigned SlotW    = $clog2(MaxContexts + 1);
  localparam int unsigned TagIdxW  = (MaxContexts > 1) ? $clog2(MaxContexts) : 1;
  localparam int unsigned CntW     = $clog2(MaxInputs + 1);
  localparam int unsigned ElemIdxW = (MaxInputs > 1) ? $clog2(MaxInputs) : 1;
  localparam int unsigned WtDepth  = (MaxContexts + 1) * MaxInputs;
  localparam int unsigned WtAddrW  = $clog2(WtDepth);
  localparam int unsigned AccW     = 48 + CntW;
  localparam logic [SlotW-1:0] FbSlot = SlotW'(MaxContexts);

  // Configuration registers.
  logic [6:0]         main_q;
  logic [5:0]         extra_q;
  logic [15:0]        lr_q;
  logic signed [31:0] sw_q;
  logic               sw_wr;

  // Latched request.
  logic [5:0]         idx_q;
  logic signed [15:0] val_q;
  logic [63:0]        key_q;
  logic               bit_q;

  // Search and loop state.
  logic [SlotW-1:0]   k_q, fill_q, slot_q;
  logic               ins_q, fb_q;
  logic [CntW-1:0]    i_q, n;
  logic [7:0]         sum8;

  // Arithmetic registers.
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0]     last_pred_q;
  logic [16:0]            s_q, decay_q;
  logic signed [34:0]     prod_q;
  logic [24:0]            step_q;
  logic signed [37:0]     u_q;
  logic signed [27:0]     d_q;
  logic signed [31:0]     w_q;

  // Result register.
  logic               out_valid_q, ufb_q;
  logic signed [31:0] pred_q;

  // Memory ports.
  logic [ElemIdxW-1:0] st_addr;
  logic                st_we;
  logic [15:0]         st_rdata;
  logic [63:0]         tag_rdata;
  logic [SlotW-1:0]    wslot;
  logic [WtAddrW-1:0]  wt_addr;
  logic                wt_we;
  logic [31:0]         wt_wdata, wt_rdata;

  // Combinational arithmetic.
  logic signed [31:0]     mac_w;
  logic signed [47:0]     mprod;
  logic signed [AccW-1:0] acc_rnd;
  logic signed [31:0]     pred;
  logic signed [17:0]     err;
  logic signed [34:0]     prod_d;
  logic signed [52:0]     ufull;
  logic signed [52:0]     ushift;
  logic signed [53:0]     dfull;
  logic signed [53:0]     dshift;
  logic signed [31:0]     w_new;
  logic [16:0]            decay_d;

  assign sw_wr = cfg_we_i && (cfg_idx_i == RegStartWeight);

  // Active element count, clamped to the store depth.
  assign sum8 = {1'b0, main_q} + {2'b0, extra_q};
  assign n    = (32'(sum8) > MaxInputs) ? CntW'(MaxInputs) : CntW'(sum8);

  // Memories.
  assign st_addr = cmd_i.store_wr ? ElemIdxW'(idx_q) : i_q[ElemIdxW-1:0];
  assign st_we   = cmd_i.store_wr && (32'(idx_q) < MaxInputs);

  cgm_ram #(.Width(16), .Depth(MaxInputs)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (val_q),
    .rdata_o (st_rdata)
  );

  cgm_ram #(.Width(64), .Depth(MaxContexts)) u_tags (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins),
    .addr_i  (k_q[TagIdxW-1:0]),
    .wdata_i (key_q),
    .rdata_o (tag_rdata)
  );

  assign wslot    = cmd_i.fill ? FbSlot : slot_q;
  assign wt_addr  = WtAddrW'(wslot) * WtAddrW'(MaxInputs) + WtAddrW'(i_q[ElemIdxW-1:0]);
  assign wt_we    = cmd_i.wt_init || cmd_i.wwr;
  assign wt_wdata = cmd_i.wwr ? w_new : sw_q;

  cgm_ram #(.Width(32), .Depth(WtDepth)) u_weights (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .addr_i  (wt_addr),
    .wdata_i (wt_wdata),
    .rdata_o (wt_rdata)
  );

  // Dot product step and output rounding.
  assign mac_w   = ins_q ? sw_q : $signed(wt_rdata);
  assign mprod   = $signed(st_rdata) * mac_w;
  assign acc_rnd = (acc_q + AccW'(1024)) >>> 11;
  assign pred    = sat32(64'(acc_rnd));

  // Learning step arithmetic.
  assign err    = $signed({1'b0, s_q}) - (bit_q ? 18'sd65536 : 18'sd0);
  assign prod_d = $signed({1'b0, lr_q}) * err;
  assign ufull  = prod_q * $signed({1'b0, decay_q});
  assign ushift = (ufull + 53'sd32768) >>> 16;
  assign dfull  = u_q * $signed(st_rdata);
  assign dshift = (dfull + 54'sd67108864) >>> 27;
  assign w_new  = sat32(64'(w_q) - 64'(d_q));

  // Decay picked by the count before it advances.
  always_comb begin
    if (step_q < StepThr1) begin
      decay_d = Decay0;
    end else if (step_q < StepThr2) begin
      decay_d = Decay1;
    end else if (step_q < StepThr3) begin
      decay_d = Decay2;
    end else begin
      decay_d = Decay3;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.k_end    = (k_q == fill_q);
    sts_o.full     = (fill_q == FbSlot);
    sts_o.tag_eq   = (tag_rdata == key_q);
    sts_o.i_n      = (i_q == n);
    sts_o.i_all    = (i_q == CntW'(MaxInputs));
    sts_o.ins      = ins_q;
    sts_o.sw_wr    = sw_wr;
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.tiny     = (prod_q == '0) && (extra_q != '0);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= 7'd32;
      extra_q     <= 6'd0;
      lr_q        <= 16'd328;
      sw_q        <= 32'sd0;
      k_q         <= '0;
      fill_q      <= '0;
      slot_q      <= FbSlot;
      ins_q       <= 1'b0;
      fb_q        <= 1'b0;
      i_q         <= '0;
      last_pred_q <= 32'sd0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMainCount:   main_q  <= cfg_wdata_i[6:0];
          RegExtraCount:  extra_q <= cfg_wdata_i[5:0];
          RegLearnRate:   lr_q    <= cfg_wdata_i[15:0];
          RegStartWeight: sw_q    <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.ins) begin
        fill_q <= fill_q + 1'b1;
        slot_q <= k_q;
        ins_q  <= 1'b1;
        fb_q   <= 1'b0;
      end else if (cmd_i.hit) begin
        slot_q <= k_q;
        ins_q  <= 1'b0;
        fb_q   <= 1'b0;
      end else if (cmd_i.fb) begin
        slot_q <= FbSlot;
        ins_q  <= 1'b0;
        fb_q   <= 1'b1;
      end
      if (sw_wr || cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.prod && (step_q != StepMax)) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        last_pred_q <= pred;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q <= elem_index_i;
      val_q <= elem_value_i;
      key_q <= ctx_key_i;
      bit_q <= coded_bit_i;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.mac && (i_q < n)) begin
      acc_q <= acc_q + AccW'(mprod);
    end
    if (cmd_i.logi) begin
      s_q <= logistic_q16(last_pred_q);
    end
    if (cmd_i.prod) begin
      prod_q  <= prod_d;
      decay_q <= decay_d;
    end
    if (cmd_i.upd) begin
      u_q <= ushift[37:0];
    end
    if (cmd_i.dmul) begin
      d_q <= dshift[27:0];
      w_q <= $signed(wt_rdata);
    end
    if (cmd_i.out_load) begin
      pred_q <= pred;
      ufb_q  <= fb_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prediction_o    = pred_q;
  assign used_fallback_o = ufb_q;
endmodule

// File: rtl/core/context_gated_logistic_mixer_top.sv
// A load writes the element store; a perceive computes the logistic and the error product and,
// unless the update is skipped, scales and writes back each active weight. A mix compares
// tags one by one, accumulates the active elements (a new context walks all MAX_INPUTS, setting
// start weights) and waits for a free result register. Each request finishes before the next is
// taken; the result register lets the next request in. Reset clears control state, then fills
// the fallback weights with requests held off; a start_weight write when idle repeats it.
module context_gated_logistic_mixer_top import cgm_pkg::*; #(
  parameter int unsigned MAX_CONTEXTS = DefMaxContexts,
  parameter int unsigned MAX_INPUTS   = DefMaxInputs
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cgm_in_if.sink              in_i,
  cgm_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);
  cgm_cmd_t cmd;
  cgm_sts_t sts;

  // Sequencer.
  cgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  cgm_dp #(
    .MaxContexts (MAX_CONTEXTS),
    .MaxInputs   (MAX_INPUTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .elem_index_i    (in_i.elem_index),
    .elem_value_i    (in_i.elem_value),
    .ctx_key_i       (in_i.ctx_key),
    .coded_bit_i     (in_i.coded_bit),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .prediction_o    (out_o.prediction),
    .used_fallback_o (out_o.used_fallback),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );
endmodule

// File: rtl/core/cgm_checker.sv
// Port-level checker of the mixer and its bind to the top level.
module cgm_checker import cgm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] prediction_i,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i
);
  logic       in_acc, out_acc, mix_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign mix_acc = in_acc && (in_func_i == FuncMix);

  // Count mix requests whose result has not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (mix_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !mix_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(prediction_i))
    else $error("result changed while stalled");

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two mix results outstanding");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a mix request");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == FuncLoad || in_func_i == FuncMix || in_func_i == FuncPerceive)
    |=> !in_ready_i)
    else $error("request taken while previous one still in work");

  a_fill_after_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == RegStartWeight |=> !in_ready_i)
    else $error("requests accepted during fallback fill");
endmodule

bind context_gated_logistic_mixer_top cgm_checker u_cgm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .prediction_i (out_o.prediction),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i)
);
